// File: rtl/gsc_pkg.sv
// Shared types, codes and the arctangent table of the stick conditioner.
`default_nettype none
package gsc_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_INIT,
    S_ITER,
    S_DONE
  } gsc_state_t;

  localparam logic [2:0] ADDR_DZ_X = 3'd0;
  localparam logic [2:0] ADDR_DZ_Y = 3'd4;
  localparam logic [14:0] DZ_RESET = 15'd4915;
  localparam logic [3:0] DIV_BITS = 4'd15;
  localparam logic [4:0] CORDIC_LAST = 5'd17;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic [3:0] div_bit;
    logic       init;
    logic       iter;
    logic [4:0] idx;
    logic       last;
    logic       sel;
    logic       finish;
  } gsc_cmd_t;

  typedef struct packed {
    logic        present;
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] released;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] la;
    logic [15:0] ra;
    logic [15:0] lt;
    logic [15:0] rt;
  } gsc_res_t;

  // atan(2^-i), pi = 2^19
  function automatic logic [17:0] gsc_atan(input logic [4:0] i);
    logic [17:0] v;
    unique case (i)
      5'd0:  v = 18'd131072;
      5'd1:  v = 18'd77376;
      5'd2:  v = 18'd40884;
      5'd3:  v = 18'd20753;
      5'd4:  v = 18'd10417;
      5'd5:  v = 18'd5213;
      5'd6:  v = 18'd2607;
      5'd7:  v = 18'd1304;
      5'd8:  v = 18'd652;
      5'd9:  v = 18'd326;
      5'd10: v = 18'd163;
      5'd11: v = 18'd81;
      5'd12: v = 18'd41;
      5'd13: v = 18'd20;
      5'd14: v = 18'd10;
      5'd15: v = 18'd5;
      5'd16: v = 18'd3;
      5'd17: v = 18'd1;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gsc_ctrl.sv
// Sequencer: divide, then CORDIC and square root per stick, then hand off.
`default_nettype none
module gsc_ctrl
  import gsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     out_free,
  output gsc_cmd_t      cmd
);

  gsc_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        if (cnt_r == 5'(DIV_BITS - 4'd1)) begin
          state_nxt = S_INIT;
          sel_nxt   = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_INIT: begin
        state_nxt = S_ITER;
        cnt_nxt   = '0;
      end
      S_ITER: begin
        if (cnt_r == CORDIC_LAST) begin
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == S_IDLE);
    cmd          = '0;
    cmd.sel      = sel_r;
    cmd.idx      = cnt_r;
    cmd.div_bit  = 4'(DIV_BITS - 4'd1 - cnt_r[3:0]);
    unique case (state_r)
      S_IDLE: cmd.load     = in_tvalid;
      S_DIV:  cmd.div_step = 1'b1;
      S_INIT: cmd.init     = 1'b1;
      S_ITER: begin
        cmd.iter = 1'b1;
        cmd.last = (cnt_r == CORDIC_LAST);
      end
      S_DONE: cmd.finish   = out_free;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTH
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free) else $error("result loaded into a full output register");
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DIV)) else $error("transfer not followed by divide");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CORDIC_LAST) else $error("step counter out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/gsc_dp.sv
// Datapath: axis dividers, shared CORDIC and square root, button history.
`default_nettype none
module gsc_dp
  import gsc_pkg::*;
#(
  parameter int PAD_COUNT = 4
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gsc_cmd_t           cmd,
  input  wire logic [1:0]         pad_index,
  input  wire logic               connected,
  input  wire logic [15:0]        buttons,
  input  wire logic signed [15:0] axis_in [4],
  input  wire logic [14:0]        dz_x,
  input  wire logic [14:0]        dz_y,
  output gsc_res_t                res
);

  localparam int IW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  logic [15:0] last_r [PAD_COUNT];
  logic [15:0] last_cap_r, btn_r;
  logic        conn_r, pad_ok_r, pad_ok;
  logic [IW-1:0] pidx;

  // per-axis divider lanes: lx, ly, rx, ry
  logic [29:0] rem_r [4];
  logic [14:0] den_r [4];
  logic [14:0] q_r   [4];
  logic        zero_r[4];
  logic        neg_r [4];
  logic signed [15:0] axv [4];

  logic signed [27:0] cx_r, cy_r, cx_nxt, cy_nxt, dxs, dys;
  logic signed [21:0] z_r, z_nxt, at;
  logic signed [21:0] zr;
  logic        spec_r;
  logic [15:0] spec_val_r;
  logic [29:0] sqx_r, sqy_r;
  logic [31:0] v_r, res_r, bitv, sum;
  logic [3:0]  k;
  logic [15:0] ang_r [2];
  logic [15:0] tilt_r[2];

  logic signed [15:0] xs, ys;
  logic [14:0] axa, aya;
  logic signed [27:0] cx0, cy0;

  assign pad_ok = (32'(pad_index) < PAD_COUNT);
  assign pidx   = IW'(pad_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAD_COUNT; p++) last_r[p] <= '0;
    end else if (cmd.load && connected && pad_ok) begin
      last_r[pidx] <= buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_cap_r <= pad_ok ? last_r[pidx] : 16'd0;
      btn_r      <= buttons;
      conn_r     <= connected;
      pad_ok_r   <= pad_ok;
    end
  end

  // divider lanes: q = (m - dz) * 32767 / (32767 - dz), one bit a cycle
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      logic [14:0] mag, dz, d;
      logic [30:0] trial;
      dz    = l[0] ? dz_y : dz_x;
      mag   = (axis_in[l] == 16'sh8000) ? 15'h7FFF :
              (axis_in[l][15] ? 15'(-axis_in[l]) : axis_in[l][14:0]);
      d     = mag - dz;
      trial = {1'b0, rem_r[l]} - (31'(den_r[l]) << cmd.div_bit);
      if (cmd.load) begin
        neg_r[l]  <= axis_in[l][15];
        zero_r[l] <= (mag <= dz);
        den_r[l]  <= 15'h7FFF - dz;
        rem_r[l]  <= {d, 15'd0} - 30'(d);
        q_r[l]    <= '0;
      end else if (cmd.div_step) begin
        q_r[l] <= {q_r[l][13:0], ~trial[30]};
        if (!trial[30]) rem_r[l] <= trial[29:0];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      axv[l] = zero_r[l] ? 16'sd0 :
               (neg_r[l] ? -$signed({1'b0, q_r[l]}) : $signed({1'b0, q_r[l]}));
    end
  end

  // CORDIC vectoring and square root for the selected stick
  always_comb begin
    xs  = cmd.sel ? axv[2] : axv[0];
    ys  = cmd.sel ? axv[3] : axv[1];
    axa = xs[15] ? 15'(-xs) : xs[14:0];
    aya = ys[15] ? 15'(-ys) : ys[14:0];
    cx0 = {{4{xs[15]}}, xs, 8'd0};
    cy0 = {{4{ys[15]}}, ys, 8'd0};
    dxs = cy_r >>> cmd.idx;
    dys = cx_r >>> cmd.idx;
    at  = $signed({4'd0, gsc_atan(cmd.idx)});
    if (!cy_r[27]) begin
      cx_nxt = cx_r + dxs;
      cy_nxt = cy_r - dys;
      z_nxt  = z_r + at;
    end else begin
      cx_nxt = cx_r - dxs;
      cy_nxt = cy_r + dys;
      z_nxt  = z_r - at;
    end
    zr   = z_nxt + 22'sd8;
    k    = 4'(cmd.idx - 5'd1);
    bitv = 32'h4000_0000 >> {k, 1'b0};
    sum  = res_r + bitv;
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      sqx_r <= axa * axa;
      sqy_r <= aya * aya;
      spec_r <= (xs == 16'sd0) || (ys == 16'sd0);
      if (ys == 16'sd0)      spec_val_r <= xs[15] ? 16'h8000 : 16'h0000;
      else if (xs[15] == 1'b0 && xs == 16'sd0) spec_val_r <= ys[15] ? 16'hC000 : 16'h4000;
      else                   spec_val_r <= 16'h0000;
      if (xs[15]) begin
        if (!ys[15]) begin
          cx_r <= cy0;
          cy_r <= -cx0;
          z_r  <= 22'sd262144;
        end else begin
          cx_r <= -cy0;
          cy_r <= cx0;
          z_r  <= -22'sd262144;
        end
      end else begin
        cx_r <= cx0;
        cy_r <= cy0;
        z_r  <= '0;
      end
    end else if (cmd.iter) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      z_r  <= z_nxt;
      if (cmd.idx == 5'd0) begin
        v_r   <= 32'(sqx_r) + 32'(sqy_r);
        res_r <= '0;
      end else if (cmd.idx <= 5'd16) begin
        if (v_r >= sum) begin
          v_r   <= v_r - sum;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      if (cmd.last) begin
        ang_r[cmd.sel]  <= spec_r ? spec_val_r : zr[19:4];
        tilt_r[cmd.sel] <= (res_r > 32'd32768) ? 16'h8000 : res_r[15:0];
      end
    end
  end

  always_comb begin
    logic ok;
    ok           = conn_r && pad_ok_r;
    res.present  = ok;
    res.held     = !pad_ok_r ? 16'd0 : (conn_r ? btn_r : last_cap_r);
    res.pressed  = ok ? (btn_r & ~last_cap_r) : 16'd0;
    res.released = ok ? (last_cap_r & ~btn_r) : 16'd0;
    res.lx       = ok ? axv[0] : 16'd0;
    res.ly       = ok ? axv[1] : 16'd0;
    res.rx       = ok ? axv[2] : 16'd0;
    res.ry       = ok ? axv[3] : 16'd0;
    res.la       = ok ? ang_r[0] : 16'd0;
    res.ra       = ok ? ang_r[1] : 16'd0;
    res.lt       = ok ? tilt_r[0] : 16'd0;
    res.rt       = ok ? tilt_r[1] : 16'd0;
  end

endmodule
`default_nettype wire

// File: rtl/gamepad_stick_conditioner.sv
// Gamepad stick conditioner: top level with config registers and output register.
//
// Input stream: one pad poll sample per transfer (pad index and connected
// flag in in_tuser, buttons and four raw axes in in_tdata).
// Output stream: one result per input: conditioned axes, stick angles and
// tilts, held/pressed/released button masks; pad_present in out_tuser.
// Steps: accept, divide (four axes in parallel lanes), then CORDIC and square
// root side by side for the left stick and then the right stick, and hand-off.
// in_tready is high only while the sequencer is idle; one item is in work.
// The result sits in an output register; a new item is accepted while it
// waits, and a finished item waits in the sequencer if that register is full.
// Reset (rst_n low, synchronous) clears button history of all pads, sets
// both deadzones to 4915 and empties the output register.
// Config: APB-style, horizontal deadzone at 0x0, vertical deadzone at 0x4,
// write only idle.
`default_nettype none
module gamepad_stick_conditioner
  import gsc_pkg::*;
#(
  parameter int PAD_COUNT = 4
)(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,   // buttons, left_x, left_y, right_x, right_y
  input  wire logic [2:0]   in_tuser,   // pad_index, connected
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // buttons_held, buttons_pressed, buttons_released, left_x_out, left_y_out,
  // right_x_out, right_y_out, left_angle, right_angle, left_tilt, right_tilt
  output logic [175:0]      out_tdata,
  output logic [0:0]        out_tuser,  // pad_present
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [14:0] dz_x_r, dz_y_r;
  logic        out_valid_r;
  gsc_res_t    out_r;
  gsc_res_t    res;
  gsc_cmd_t    cmd;
  logic        out_free;
  logic signed [15:0] axis_in [4];

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_x_r <= DZ_RESET;
      dz_y_r <= DZ_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == ADDR_DZ_X) dz_x_r <= cfg_pwdata[14:0];
      if (cfg_paddr == ADDR_DZ_Y) dz_y_r <= cfg_pwdata[14:0];
    end
  end

  always_comb begin
    if (cfg_paddr == ADDR_DZ_X)      cfg_prdata = {17'd0, dz_x_r};
    else if (cfg_paddr == ADDR_DZ_Y) cfg_prdata = {17'd0, dz_y_r};
    else                             cfg_prdata = 32'd0;
  end

  assign axis_in[0] = in_tdata[31:16];
  assign axis_in[1] = in_tdata[47:32];
  assign axis_in[2] = in_tdata[63:48];
  assign axis_in[3] = in_tdata[79:64];

  assign out_free = !out_valid_r || out_tready;

  gsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  gsc_dp #(.PAD_COUNT(PAD_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pad_index (in_tuser[1:0]),
    .connected (in_tuser[2]),
    .buttons   (in_tdata[15:0]),
    .axis_in   (axis_in),
    .dz_x      (dz_x_r),
    .dz_y      (dz_y_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.present;
  assign out_tdata  = {out_r.rt, out_r.lt, out_r.ra, out_r.la, out_r.ry, out_r.rx,
                       out_r.ly, out_r.lx, out_r.released, out_r.pressed, out_r.held};

endmodule
`default_nettype wire
